// ----- rtl/fap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fap_pkg
// Shared types and constants of the page frame allocator: command and status
// codes, sequencer states and the command and result structs.
// ----------------------------------------------------------------------------
package fap_pkg;

    localparam int ADDR_W         = 48;
    localparam int REF_W          = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int NUM_FRAMES_DEF = 4096;

    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_REL   = 2'd2,
        CMD_INC   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OOM       = 3'd1,
        ST_HEAD_BUSY = 3'd2,
        ST_INVALID   = 3'd3,
        ST_UNALLOC   = 3'd4,
        ST_FULL      = 3'd5,
        ST_OVERFLOW  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CFG_RES_LOW  = 2'd0,
        CFG_RES_HIGH = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LINK,
        S_ALLOC,
        S_SEARCH
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] page_addr;
    } t_cmd_item;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        t_status           status;
        logic [REF_W-1:0]  ref_count;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/fap_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fap_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/fap_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fap_window
// Reserved window registers and the window membership check.
// ----------------------------------------------------------------------------
module fap_window (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [fap_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fap_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire logic [fap_pkg::ADDR_W-1:0]    i_addr,
    output logic                               o_in_window
);

    logic [fap_pkg::ADDR_W-1:0] r_low;
    logic [fap_pkg::ADDR_W-1:0] r_high;

    // Take register transfers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == fap_pkg::CFG_RES_LOW) begin
                r_low <= i_cfg_data;
            end
            if (i_cfg_index == fap_pkg::CFG_RES_HIGH) begin
                r_high <= i_cfg_data;
            end
        end
    end

    // Half-open window check
    assign o_in_window = (i_addr >= r_low) && (i_addr < r_high);

endmodule
`default_nettype wire

// ----- rtl/page_frame_allocator_refcount.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Page frame allocator with a free list and per-frame reference counts.
//
//   channel   direction  handshake               payload
//   command   in         start && !busy          i_cmd_item (cmd, page_addr)
//   result    out        o_done, one cycle       o_result (addr, status, count)
//   config    in         i_cfg_valid, ready = 1  i_cfg_index, i_cfg_data
//
// Release and increment scan the frame table through one address comparator,
// one entry per cycle from the base RAM read port. busy stays high until the
// result is issued; the result is a one-cycle strobe that the receiver cannot
// stall. Synchronous active-low reset empties the free list and the table;
// frame RAMs are not cleared.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount #(
    parameter int NUM_FRAMES = fap_pkg::NUM_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire fap_pkg::t_cmd_item            i_cmd_item,
    output logic                               o_done,
    output fap_pkg::t_result                   o_result,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fap_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fap_pkg::ADDR_W-1:0]    i_cfg_data
);

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int PW = $clog2(NUM_FRAMES + 1);
    localparam logic [PW-1:0] NO_FRAME = PW'(NUM_FRAMES);

    fap_pkg::t_state             r_state,  n_state;
    fap_pkg::t_cmd               r_cmd,    n_cmd;
    logic [fap_pkg::ADDR_W-1:0]  r_addr,   n_addr;
    logic [PW-1:0]               r_head,   n_head;
    logic [PW-1:0]               r_tail,   n_tail;
    logic [PW-1:0]               r_loaded, n_loaded;
    logic [IW-1:0]               r_i,      n_i;
    logic                        r_done,   n_done;
    fap_pkg::t_result            r_res,    n_res;

    logic                        in_window;
    logic [IW-1:0]               rd_addr;
    logic                        base_we, refs_we, next_we;
    logic [IW-1:0]               base_wa, refs_wa, next_wa;
    logic [fap_pkg::ADDR_W-1:0]  base_wd, base_rd;
    logic [fap_pkg::REF_W-1:0]   refs_wd, refs_rd, ref_dec;
    logic [PW-1:0]               next_wd, next_rd;

    // Window registers and check
    fap_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_addr      (r_addr),
        .o_in_window (in_window)
    );

    // Frame tables
    fap_ram #(.WIDTH(fap_pkg::ADDR_W), .DEPTH(NUM_FRAMES)) u_base (
        .i_clk(i_clk), .i_we(base_we), .i_waddr(base_wa), .i_wdata(base_wd),
        .i_raddr(rd_addr), .o_rdata(base_rd)
    );
    fap_ram #(.WIDTH(fap_pkg::REF_W), .DEPTH(NUM_FRAMES)) u_refs (
        .i_clk(i_clk), .i_we(refs_we), .i_waddr(refs_wa), .i_wdata(refs_wd),
        .i_raddr(rd_addr), .o_rdata(refs_rd)
    );
    fap_ram #(.WIDTH(PW), .DEPTH(NUM_FRAMES)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(rd_addr), .o_rdata(next_rd)
    );

    assign ref_dec = refs_rd - fap_pkg::REF_W'(1);

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fap_pkg::S_IDLE;
            r_head   <= NO_FRAME;
            r_tail   <= NO_FRAME;
            r_loaded <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_loaded <= n_loaded;
            r_done   <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_addr <= n_addr;
        r_i    <= n_i;
        r_res  <= n_res;
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_head   = r_head;
        n_tail   = r_tail;
        n_loaded = r_loaded;
        n_i      = r_i;
        n_done   = 1'b0;
        n_res    = r_res;
        rd_addr  = r_i;
        base_we  = 1'b0;
        base_wa  = r_loaded[IW-1:0];
        base_wd  = r_addr;
        refs_we  = 1'b0;
        refs_wa  = r_i;
        refs_wd  = '0;
        next_we  = 1'b0;
        next_wa  = r_i;
        next_wd  = NO_FRAME;

        case (r_state)
            fap_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd_item.cmd;
                    n_addr  = i_cmd_item.page_addr;
                    n_state = fap_pkg::S_DISPATCH;
                end
            end

            fap_pkg::S_DISPATCH: begin
                n_res = '{result_addr: '0, status: fap_pkg::ST_OK, ref_count: '0};
                case (r_cmd)
                    fap_pkg::CMD_LOAD: begin
                        if (r_loaded >= NO_FRAME) begin
                            n_res.status = fap_pkg::ST_FULL;
                            n_done       = 1'b1;
                            n_state      = fap_pkg::S_IDLE;
                        end else begin
                            // Fill the new entry
                            base_we  = 1'b1;
                            refs_we  = 1'b1;
                            refs_wa  = r_loaded[IW-1:0];
                            refs_wd  = in_window ? fap_pkg::REF_W'(1) : '0;
                            next_we  = 1'b1;
                            next_wa  = r_loaded[IW-1:0];
                            n_loaded = r_loaded + PW'(1);
                            n_i      = r_loaded[IW-1:0];
                            n_res.ref_count = refs_wd;
                            if (in_window) begin
                                n_done  = 1'b1;
                                n_state = fap_pkg::S_IDLE;
                            end else if (r_head == NO_FRAME || r_tail >= NO_FRAME) begin
                                n_head  = r_loaded;
                                n_tail  = r_loaded;
                                n_done  = 1'b1;
                                n_state = fap_pkg::S_IDLE;
                            end else begin
                                n_state = fap_pkg::S_LINK;
                            end
                        end
                    end
                    fap_pkg::CMD_ALLOC: begin
                        if (r_head >= NO_FRAME) begin
                            n_res.status = fap_pkg::ST_OOM;
                            n_done       = 1'b1;
                            n_state      = fap_pkg::S_IDLE;
                        end else begin
                            rd_addr = r_head[IW-1:0];
                            n_i     = r_head[IW-1:0];
                            n_state = fap_pkg::S_ALLOC;
                        end
                    end
                    default: begin
                        // Release and increment scan from entry zero
                        if (r_loaded == '0) begin
                            n_res.status = fap_pkg::ST_INVALID;
                            n_done       = 1'b1;
                            n_state      = fap_pkg::S_IDLE;
                        end else begin
                            rd_addr = '0;
                            n_i     = '0;
                            n_state = fap_pkg::S_SEARCH;
                        end
                    end
                endcase
            end

            fap_pkg::S_LINK: begin
                // Append the new free entry behind the tail
                next_we = 1'b1;
                next_wa = r_tail[IW-1:0];
                next_wd = PW'(r_i);
                n_tail  = PW'(r_i);
                n_done  = 1'b1;
                n_state = fap_pkg::S_IDLE;
            end

            fap_pkg::S_ALLOC: begin
                n_done  = 1'b1;
                n_state = fap_pkg::S_IDLE;
                if (refs_rd != '0) begin
                    n_res.status    = fap_pkg::ST_HEAD_BUSY;
                    n_res.ref_count = refs_rd;
                end else begin
                    // Pop the head
                    refs_we = 1'b1;
                    refs_wd = fap_pkg::REF_W'(1);
                    next_we = 1'b1;
                    if (next_rd >= NO_FRAME) begin
                        n_head = NO_FRAME;
                        n_tail = NO_FRAME;
                    end else begin
                        n_head = next_rd;
                    end
                    n_res.result_addr = base_rd;
                    n_res.ref_count   = fap_pkg::REF_W'(1);
                end
            end

            fap_pkg::S_SEARCH: begin
                rd_addr = r_i + IW'(1);
                if (base_rd == r_addr) begin
                    n_done  = 1'b1;
                    n_state = fap_pkg::S_IDLE;
                    if (refs_rd == '0) begin
                        n_res.status = fap_pkg::ST_UNALLOC;
                    end else if (r_cmd == fap_pkg::CMD_REL) begin
                        // Drop one reference, free on zero
                        refs_we         = 1'b1;
                        refs_wd         = ref_dec;
                        n_res.ref_count = ref_dec;
                        if (ref_dec == '0) begin
                            next_we = 1'b1;
                            next_wd = r_head;
                            if (r_head >= NO_FRAME) begin
                                n_tail = PW'(r_i);
                            end
                            n_head = PW'(r_i);
                        end
                    end else if (refs_rd >= fap_pkg::REF_MAX) begin
                        n_res.status    = fap_pkg::ST_OVERFLOW;
                        n_res.ref_count = refs_rd;
                    end else begin
                        refs_we         = 1'b1;
                        refs_wd         = refs_rd + fap_pkg::REF_W'(1);
                        n_res.ref_count = refs_wd;
                    end
                end else if (PW'(r_i) + PW'(1) == r_loaded) begin
                    n_res.status = fap_pkg::ST_INVALID;
                    n_done       = 1'b1;
                    n_state      = fap_pkg::S_IDLE;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end

            default: begin
                n_state = fap_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != fap_pkg::S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result issued without a command in progress");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NO_FRAME) == (r_tail == NO_FRAME))
        else $error("free list head and tail disagree on empty");

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= NO_FRAME)
        else $error("frame count beyond table size");
`endif

endmodule
`default_nettype wire
